[hw/rtl/voxel_occupancy_grid_assert.svh]
// Assertion macros for the RTL of the voxel grid.
`ifndef VOXEL_OCCUPANCY_GRID_ASSERT_SVH
`define VOXEL_OCCUPANCY_GRID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VOG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VOG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/vog_pkg.sv]
`timescale 1ns / 1ps

package vog_pkg;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_DECAY = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X          = 3'd0,
    CFG_ORIGIN_Y          = 3'd1,
    CFG_ORIGIN_Z          = 3'd2,
    CFG_INVERSE_RES       = 3'd3,
    CFG_CONFIRM_THRESHOLD = 3'd4,
    CFG_OBSTACLE_MARKER   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_CELL,
    S_RD,
    S_MODIFY,
    S_BOX_RD,
    S_BOX_CHK,
    S_OUT
  } state_t;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [7:0]  ADD_STEP    = 8'd2;
  localparam logic [7:0]  COUNT_MAX   = 8'd255;
  localparam logic [31:0] INV_RES_RST = 32'd327680;
  localparam logic [7:0]  THRESH_RST  = 8'd10;
  localparam logic [7:0]  MARKER_RST  = 8'd255;

endpackage

[hw/rtl/voxel_occupancy_grid.sv]
`timescale 1ns / 1ps
// Decay reads and updates the cell at its index, or goes straight to the result for an
// index off the grid. Mark, add and query first map each axis to a cell, and query then
// walks its box unless an extent is zero, visiting at most 8 * MAX_EXTENT^3 cells.
// One request at a time; the next is taken in the cycle after the result is loaded. A
// shared 32x32 multiplier maps the three axes in turn. Reset loads the register defaults,
// then zeroes all 2^(XW+YW+ZW) grid cells, one cell a cycle; no request is taken then.

module voxel_occupancy_grid #(
  parameter int GRID_X_SIZE = 64,
  parameter int GRID_Y_SIZE = 64,
  parameter int GRID_Z_SIZE = 32,
  parameter int MAX_EXTENT  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vog_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   operation,
  input  logic signed [31:0]           coord_x,
  input  logic signed [31:0]           coord_y,
  input  logic signed [31:0]           coord_z,
  input  logic [5:0]                   cell_x,
  input  logic [5:0]                   cell_y,
  input  logic [4:0]                   cell_z,
  input  logic [3:0]                   extent_x,
  input  logic [3:0]                   extent_y,
  input  logic [3:0]                   extent_z,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         in_bounds,
  output logic                         box_free,
  output logic [7:0]                   cell_value
);

  `include "voxel_occupancy_grid_assert.svh"

  localparam int XW = (GRID_X_SIZE > 1) ? $clog2(GRID_X_SIZE) : 1;
  localparam int YW = (GRID_Y_SIZE > 1) ? $clog2(GRID_Y_SIZE) : 1;
  localparam int ZW = (GRID_Z_SIZE > 1) ? $clog2(GRID_Z_SIZE) : 1;
  localparam int AW = XW + YW + ZW;
  localparam int DEPTH = 1 << AW;
  localparam int EW = $clog2(MAX_EXTENT + 1) + 1;
  localparam int MW = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
  localparam int PW = MW + EW + 2;

  vog_pkg::state_t state, state_next;

  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [31:0]        inv_res;
  logic [7:0]         threshold;
  logic [7:0]         marker;

  vog_pkg::op_t       op_q;
  logic signed [31:0] crd_x, crd_y, crd_z;
  logic [EW-1:0]      ext_x, ext_y, ext_z;
  logic [1:0]         axis;
  logic [32:0]        diff;
  logic               neg;
  logic [63:0]        prod;
  logic [XW-1:0]      cx;
  logic [YW-1:0]      cy;
  logic [ZW-1:0]      cz;
  logic               ok_x, ok_y, ok_z;

  logic signed [PW-1:0] bx, by, bz;
  logic signed [PW-1:0] lx, ly, lz;
  logic signed [PW-1:0] px, py, pz;
  logic                 box_cell_ok;

  logic        res_in_bounds;
  logic        res_free;
  logic [7:0]  res_value;

  logic [AW-1:0] clr_addr;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;
  logic          load_out;

  logic [AW-1:0] center_addr;
  logic [AW-1:0] box_addr;
  logic          dec_ok;
  logic [31:0]   axis_size;
  logic [31:0]   q;
  logic          ok_sel;
  logic [31:0]   cell_sel;
  logic          all_ok_now;
  logic          ext_zero;
  logic          box_in;
  logic          box_hit;
  logic          box_last;
  logic [7:0]    new_val;
  logic signed [31:0] crd_sel;
  logic signed [31:0] org_sel;
  logic [EW-1:0] ext_sat_x, ext_sat_y, ext_sat_z;

  assign center_addr = {cx, cy, cz};
  assign box_addr    = {px[XW-1:0], py[YW-1:0], pz[ZW-1:0]};
  assign dec_ok      = (32'(cell_x) < 32'(GRID_X_SIZE)) && (32'(cell_y) < 32'(GRID_Y_SIZE))
                       && (32'(cell_z) < 32'(GRID_Z_SIZE));
  assign q           = prod[63:32];
  assign ok_sel      = !neg && (q < axis_size);
  assign cell_sel    = neg ? 32'd0 : ((q < axis_size) ? q : axis_size - 32'd1);
  assign all_ok_now  = ok_x && ok_y && ok_sel;
  assign ext_zero    = (ext_x == '0) || (ext_y == '0) || (ext_z == '0);
  assign box_in      = !px[PW-1] && (px < $signed(PW'(GRID_X_SIZE)))
                       && !py[PW-1] && (py < $signed(PW'(GRID_Y_SIZE)))
                       && !pz[PW-1] && (pz < $signed(PW'(GRID_Z_SIZE)));
  assign box_hit     = box_cell_ok && (rd_data >= marker);
  assign box_last    = (px == lx) && (py == ly) && (pz == lz);

  assign ext_sat_x = (32'(extent_x) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(extent_x);
  assign ext_sat_y = (32'(extent_y) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(extent_y);
  assign ext_sat_z = (32'(extent_z) > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(extent_z);

  always_comb begin
    case (axis)
      vog_pkg::AX_X: begin
        axis_size = 32'(GRID_X_SIZE);
        crd_sel   = crd_x;
        org_sel   = origin_x;
      end
      vog_pkg::AX_Y: begin
        axis_size = 32'(GRID_Y_SIZE);
        crd_sel   = crd_y;
        org_sel   = origin_y;
      end
      default: begin
        axis_size = 32'(GRID_Z_SIZE);
        crd_sel   = crd_z;
        org_sel   = origin_z;
      end
    endcase
  end

  always_comb begin
    new_val = rd_data;
    case (op_q)
      vog_pkg::OP_MARK: begin
        new_val = marker;
      end
      vog_pkg::OP_ADD: begin
        if (rd_data != marker) begin
          new_val = (rd_data > vog_pkg::COUNT_MAX - vog_pkg::ADD_STEP) ?
                    vog_pkg::COUNT_MAX : rd_data + vog_pkg::ADD_STEP;
        end
      end
      vog_pkg::OP_DECAY: begin
        if (rd_data != marker) begin
          if (rd_data > threshold) begin
            new_val = marker;
          end else if (rd_data != 8'd0) begin
            new_val = rd_data - 8'd1;
          end
        end
      end
      default: begin
        new_val = rd_data;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      vog_pkg::S_CLEAR: begin
        if (clr_addr == '1) state_next = vog_pkg::S_IDLE;
      end
      vog_pkg::S_IDLE: begin
        if (req_valid) begin
          if (vog_pkg::op_t'(operation) == vog_pkg::OP_DECAY) begin
            state_next = dec_ok ? vog_pkg::S_RD : vog_pkg::S_OUT;
          end else begin
            state_next = vog_pkg::S_DIFF;
          end
        end
      end
      vog_pkg::S_DIFF: state_next = vog_pkg::S_MUL;
      vog_pkg::S_MUL:  state_next = vog_pkg::S_CELL;
      vog_pkg::S_CELL: begin
        if (axis != vog_pkg::AX_Z) begin
          state_next = vog_pkg::S_DIFF;
        end else if (op_q == vog_pkg::OP_QUERY || all_ok_now) begin
          state_next = vog_pkg::S_RD;
        end else begin
          state_next = vog_pkg::S_OUT;
        end
      end
      vog_pkg::S_RD: state_next = vog_pkg::S_MODIFY;
      vog_pkg::S_MODIFY: begin
        if (op_q == vog_pkg::OP_QUERY && !ext_zero) begin
          state_next = vog_pkg::S_BOX_RD;
        end else begin
          state_next = vog_pkg::S_OUT;
        end
      end
      vog_pkg::S_BOX_RD: state_next = vog_pkg::S_BOX_CHK;
      vog_pkg::S_BOX_CHK: begin
        state_next = (box_hit || box_last) ? vog_pkg::S_OUT : vog_pkg::S_BOX_RD;
      end
      vog_pkg::S_OUT: begin
        if (!rsp_valid || rsp_ready) state_next = vog_pkg::S_IDLE;
      end
      default: state_next = vog_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cfg_ready = 1'b1;
    req_ready = (state == vog_pkg::S_IDLE);
    load_out  = (state == vog_pkg::S_OUT) && (!rsp_valid || rsp_ready);
    mem_raddr = (state == vog_pkg::S_BOX_RD) ? box_addr : center_addr;
    if (state == vog_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 8'd0;
    end else begin
      mem_we    = (state == vog_pkg::S_MODIFY) && (op_q != vog_pkg::OP_QUERY);
      mem_waddr = center_addr;
      mem_wdata = new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vog_pkg::S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      inv_res   <= vog_pkg::INV_RES_RST;
      threshold <= vog_pkg::THRESH_RST;
      marker    <= vog_pkg::MARKER_RST;
      axis      <= vog_pkg::AX_X;
    end else begin
      state <= state_next;
      if (state == vog_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vog_pkg::CFG_ORIGIN_X:          origin_x  <= cfg_data;
          vog_pkg::CFG_ORIGIN_Y:          origin_y  <= cfg_data;
          vog_pkg::CFG_ORIGIN_Z:          origin_z  <= cfg_data;
          vog_pkg::CFG_INVERSE_RES:       inv_res   <= cfg_data;
          vog_pkg::CFG_CONFIRM_THRESHOLD: threshold <= cfg_data[7:0];
          vog_pkg::CFG_OBSTACLE_MARKER:   marker    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state == vog_pkg::S_IDLE) begin
        axis <= vog_pkg::AX_X;
      end else if (state == vog_pkg::S_CELL) begin
        axis <= axis + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      vog_pkg::S_IDLE: begin
        op_q          <= vog_pkg::op_t'(operation);
        crd_x         <= coord_x;
        crd_y         <= coord_y;
        crd_z         <= coord_z;
        ext_x         <= ext_sat_x;
        ext_y         <= ext_sat_y;
        ext_z         <= ext_sat_z;
        cx            <= XW'(cell_x);
        cy            <= YW'(cell_y);
        cz            <= ZW'(cell_z);
        res_in_bounds <= 1'b0;
        res_free      <= 1'b0;
        res_value     <= 8'd0;
      end
      vog_pkg::S_DIFF: begin
        diff <= {crd_sel[31], crd_sel} - {org_sel[31], org_sel};
      end
      vog_pkg::S_MUL: begin
        neg  <= diff[32];
        prod <= diff[31:0] * inv_res;
      end
      vog_pkg::S_CELL: begin
        case (axis)
          vog_pkg::AX_X: begin
            cx   <= XW'(cell_sel);
            ok_x <= ok_sel;
          end
          vog_pkg::AX_Y: begin
            cy   <= YW'(cell_sel);
            ok_y <= ok_sel;
          end
          default: begin
            cz   <= ZW'(cell_sel);
            ok_z <= ok_sel;
          end
        endcase
      end
      vog_pkg::S_MODIFY: begin
        if (op_q == vog_pkg::OP_QUERY) begin
          res_in_bounds <= ok_x && ok_y && ok_z;
          res_value     <= rd_data;
          res_free      <= ext_zero;
          bx <= $signed(PW'(cx)) - $signed(PW'(ext_x));
          by <= $signed(PW'(cy)) - $signed(PW'(ext_y));
          bz <= $signed(PW'(cz)) - $signed(PW'(ext_z));
          px <= $signed(PW'(cx)) - $signed(PW'(ext_x));
          py <= $signed(PW'(cy)) - $signed(PW'(ext_y));
          pz <= $signed(PW'(cz)) - $signed(PW'(ext_z));
          lx <= $signed(PW'(cx)) + $signed(PW'(ext_x)) - $signed(PW'(1));
          ly <= $signed(PW'(cy)) + $signed(PW'(ext_y)) - $signed(PW'(1));
          lz <= $signed(PW'(cz)) + $signed(PW'(ext_z)) - $signed(PW'(1));
        end else begin
          res_in_bounds <= 1'b1;
          res_value     <= new_val;
        end
      end
      vog_pkg::S_BOX_RD: begin
        box_cell_ok <= box_in;
      end
      vog_pkg::S_BOX_CHK: begin
        res_free <= !box_hit;
        if (pz != lz) begin
          pz <= pz + $signed(PW'(1));
        end else begin
          pz <= bz;
          if (py != ly) begin
            py <= py + $signed(PW'(1));
          end else begin
            py <= by;
            px <= px + $signed(PW'(1));
          end
        end
      end
      default: ;
    endcase
    if (load_out) begin
      in_bounds  <= res_in_bounds;
      box_free   <= res_free;
      cell_value <= res_value;
    end
  end

  `VOG_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready,
                   "request taken but block still ready")
  `VOG_ASSERT_SAME(a_write_source, clk, rst, mem_we && state != vog_pkg::S_CLEAR,
                   state == vog_pkg::S_MODIFY && op_q != vog_pkg::OP_QUERY,
                   "grid written outside an update")
  `VOG_ASSERT_SAME(a_box_only_query, clk, rst,
                   state == vog_pkg::S_BOX_RD || state == vog_pkg::S_BOX_CHK,
                   op_q == vog_pkg::OP_QUERY, "box walk for a request that is no query")
  `VOG_ASSERT_NEXT(a_load_from_out, clk, rst, load_out, rsp_valid && state == vog_pkg::S_IDLE,
                   "result load did not present a response")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import vog_pkg::*;

  localparam int GX = 64;
  localparam int GY = 64;
  localparam int GZ = 32;
  localparam int MAX_EXT = 8;
  localparam int CELLS = GX * GY * GZ;
  localparam int REPORT_LIMIT = 10;

  // Coordinates that land on a known cell at the reset scale of 5 cells per meter.
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] C_NEG1 = -32'sd1;
  localparam logic signed [31:0] CELL5 = 32'sd65540;
  localparam logic signed [31:0] CELL10 = 32'sd131080;
  localparam logic signed [31:0] CELL20 = 32'sd262160;
  localparam logic signed [31:0] CELL31 = 32'sd406348;
  localparam logic signed [31:0] CELL40 = 32'sd524320;
  localparam logic signed [31:0] CELL63 = 32'sd825804;
  localparam logic signed [31:0] CELL64 = 32'sd838912;

  typedef struct {
    op_t operation;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [4:0] cell_z;
    logic [3:0] extent_x;
    logic [3:0] extent_y;
    logic [3:0] extent_z;
  } voxel_req_t;

  typedef struct {
    logic in_bounds;
    logic box_free;
    logic [7:0] cell_value;
  } voxel_result_t;

  typedef struct {
    voxel_req_t req;
    bit known;
    voxel_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [1:0] operation = '0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic signed [31:0] coord_z = '0;
  logic [5:0] cell_x = '0;
  logic [5:0] cell_y = '0;
  logic [4:0] cell_z = '0;
  logic [3:0] extent_x = '0;
  logic [3:0] extent_y = '0;
  logic [3:0] extent_z = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic in_bounds;
  logic box_free;
  logic [7:0] cell_value;

  bit [7:0] shadow_counts [CELLS];
  logic signed [31:0] org_x = '0;
  logic signed [31:0] org_y = '0;
  logic signed [31:0] org_z = '0;
  logic [31:0] cells_per_meter = INV_RES_RST;
  logic [7:0] promote_above = THRESH_RST;
  logic [7:0] marker_code = MARKER_RST;

  voxel_result_t pending_results [$];
  voxel_result_t want;
  stim_row_t directed_rows [$];
  logic signed [31:0] pool_x [8];
  logic signed [31:0] pool_y [8];
  logic signed [31:0] pool_z [8];
  logic steady_flow = 1'b0;
  int mismatches = 0;

  voxel_occupancy_grid #(
    .GRID_X_SIZE(GX),
    .GRID_Y_SIZE(GY),
    .GRID_Z_SIZE(GZ),
    .MAX_EXTENT(MAX_EXT)
  ) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint coord_to_cell(logic signed [31:0] coord,
                                           logic signed [31:0] origin);
    longint d;
    bit [63:0] scaled;
    d = longint'(coord) - longint'(origin);
    if (d < 0) begin
      return -1;
    end
    scaled = 64'(d) * {32'd0, cells_per_meter};
    return longint'(scaled >> 32);
  endfunction

  function automatic bit in_grid(longint x, longint y, longint z);
    return x >= 0 && x < GX && y >= 0 && y < GY && z >= 0 && z < GZ;
  endfunction

  function automatic int unsigned cell_addr(longint x, longint y, longint z);
    return int'((x * GY + y) * GZ + z);
  endfunction

  function automatic longint clamp_axis(longint c, int size);
    if (c < 0) begin
      return 0;
    end
    return c >= size ? size - 1 : c;
  endfunction

  function automatic longint box_half(logic [3:0] e);
    return e > MAX_EXT ? MAX_EXT : e;
  endfunction

  function automatic voxel_result_t occupancy_step(voxel_req_t r);
    voxel_result_t res;
    longint x, y, z, ex, ey, ez, i, j, k;
    logic [7:0] v;
    bit clear;
    int unsigned a;
    res = '{1'b0, 1'b0, 8'd0};
    if (r.operation == OP_DECAY) begin
      x = r.cell_x;
      y = r.cell_y;
      z = r.cell_z;
      if (in_grid(x, y, z)) begin
        a = cell_addr(x, y, z);
        v = shadow_counts[a];
        if (v != marker_code) begin
          if (v > promote_above) begin
            v = marker_code;
          end else if (v != 8'd0) begin
            v = v - 8'd1;
          end
        end
        shadow_counts[a] = v;
        res.in_bounds = 1'b1;
        res.cell_value = v;
      end
    end else begin
      x = coord_to_cell(r.coord_x, org_x);
      y = coord_to_cell(r.coord_y, org_y);
      z = coord_to_cell(r.coord_z, org_z);
      if (r.operation == OP_QUERY) begin
        res.in_bounds = in_grid(x, y, z);
        x = clamp_axis(x, GX);
        y = clamp_axis(y, GY);
        z = clamp_axis(z, GZ);
        ex = box_half(r.extent_x);
        ey = box_half(r.extent_y);
        ez = box_half(r.extent_z);
        clear = 1'b1;
        for (i = x - ex; i < x + ex && clear; i++) begin
          for (j = y - ey; j < y + ey && clear; j++) begin
            for (k = z - ez; k < z + ez && clear; k++) begin
              if (in_grid(i, j, k) && shadow_counts[cell_addr(i, j, k)] >= marker_code) begin
                clear = 1'b0;
              end
            end
          end
        end
        res.box_free = clear;
        res.cell_value = shadow_counts[cell_addr(x, y, z)];
      end else if (in_grid(x, y, z)) begin
        a = cell_addr(x, y, z);
        v = shadow_counts[a];
        if (r.operation == OP_MARK) begin
          v = marker_code;
        end else if (v != marker_code) begin
          v = (v > COUNT_MAX - ADD_STEP) ? COUNT_MAX : v + ADD_STEP;
        end
        shadow_counts[a] = v;
        res.in_bounds = 1'b1;
        res.cell_value = v;
      end
    end
    return res;
  endfunction

  // Picks a coordinate around the grid span of one axis under the current scale.
  function automatic logic signed [31:0] pick_coord(logic signed [31:0] origin, int cells);
    longint span, off, c;
    int unsigned sel;
    span = (longint'(cells) <<< 32) / longint'({32'd0, cells_per_meter});
    sel = $urandom_range(0, 15);
    case (sel)
      0: return $urandom;
      1: off = 0;
      2: off = span;
      3: off = -1;
      default: off = span * longint'($urandom_range(0, 1151)) / 1024 - span / 8;
    endcase
    c = longint'(origin) + off;
    if (c > longint'(C_MAX)) begin
      c = longint'(C_MAX);
    end
    if (c < longint'(C_MIN)) begin
      c = longint'(C_MIN);
    end
    return c[31:0];
  endfunction

  function automatic stim_row_t stim_row(op_t op, logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z, logic [5:0] cx, logic [5:0] cy,
                                         logic [4:0] cz, logic [3:0] ex, logic [3:0] ey,
                                         logic [3:0] ez, bit known, logic ib, logic bf,
                                         logic [7:0] val);
    stim_row_t s;
    s.req = '{op, x, y, z, cx, cy, cz, ex, ey, ez};
    s.known = known;
    s.res = '{ib, bf, val};
    return s;
  endfunction

  task automatic send_request(voxel_req_t r, bit known, voxel_result_t typed);
    voxel_result_t predicted;
    while (!steady_flow && $urandom_range(0, 99) < 23) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= r.operation;
    coord_x <= r.coord_x;
    coord_y <= r.coord_y;
    coord_z <= r.coord_z;
    cell_x <= r.cell_x;
    cell_y <= r.cell_y;
    cell_z <= r.cell_z;
    extent_x <= r.extent_x;
    extent_y <= r.extent_y;
    extent_z <= r.extent_z;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
    predicted = occupancy_step(r);
    pending_results.push_back(known ? typed : predicted);
  endtask

  task automatic program_registers(logic signed [31:0] ox, logic signed [31:0] oy,
                                   logic signed [31:0] oz, logic [31:0] inv,
                                   logic [7:0] thr, logic [7:0] mark);
    cfg_reg_t order [6];
    logic [31:0] values [6];
    order = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z, CFG_INVERSE_RES,
              CFG_CONFIRM_THRESHOLD, CFG_OBSTACLE_MARKER};
    values = '{ox, oy, oz, inv, {24'd0, thr}, {24'd0, mark}};
    req_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_results.size() != 0);
    @(posedge clk);
    foreach (order[n]) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[n];
      cfg_data <= values[n];
      @(posedge clk);
      while (!cfg_ready) begin
        @(posedge clk);
      end
      case (order[n])
        CFG_ORIGIN_X: org_x = values[n];
        CFG_ORIGIN_Y: org_y = values[n];
        CFG_ORIGIN_Z: org_z = values[n];
        CFG_INVERSE_RES: cells_per_meter = values[n];
        CFG_CONFIRM_THRESHOLD: promote_above = values[n][7:0];
        CFG_OBSTACLE_MARKER: marker_code = values[n][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Most requests revisit a small set of positions so that evidence builds up on them.
  task automatic random_requests(int count, int steady);
    voxel_req_t r;
    voxel_result_t none;
    int unsigned pick, slot;
    longint c;
    none = '{1'b0, 1'b0, 8'd0};
    foreach (pool_x[s]) begin
      pool_x[s] = pick_coord(org_x, GX);
      pool_y[s] = pick_coord(org_y, GY);
      pool_z[s] = pick_coord(org_z, GZ);
    end
    steady_flow <= (steady > 0);
    for (int n = 0; n < count; n++) begin
      if (n == steady && steady > 0) begin
        steady_flow <= 1'b0;
      end
      pick = $urandom_range(0, 99);
      r.operation = pick < 15 ? OP_MARK : pick < 55 ? OP_ADD : pick < 75 ? OP_DECAY : OP_QUERY;
      slot = $urandom_range(0, 7);
      if ($urandom_range(0, 9) < 4) begin
        pool_x[slot] = pick_coord(org_x, GX);
        pool_y[slot] = pick_coord(org_y, GY);
        pool_z[slot] = pick_coord(org_z, GZ);
      end
      r.coord_x = pool_x[slot];
      r.coord_y = pool_y[slot];
      r.coord_z = pool_z[slot];
      r.cell_x = 6'($urandom);
      r.cell_y = 6'($urandom);
      r.cell_z = 5'($urandom);
      if (r.operation == OP_DECAY && $urandom_range(0, 1) == 1) begin
        c = coord_to_cell(pool_x[slot], org_x);
        if (c >= 0 && c < GX) begin
          r.cell_x = 6'(c);
        end
        c = coord_to_cell(pool_y[slot], org_y);
        if (c >= 0 && c < GY) begin
          r.cell_y = 6'(c);
        end
        c = coord_to_cell(pool_z[slot], org_z);
        if (c >= 0 && c < GZ) begin
          r.cell_z = 5'(c);
        end
      end
      if (r.operation != OP_QUERY || $urandom_range(0, 39) == 0) begin
        r.extent_x = 4'($urandom);
        r.extent_y = 4'($urandom);
        r.extent_z = 4'($urandom);
      end else begin
        r.extent_x = 4'($urandom_range(0, 3));
        r.extent_y = 4'($urandom_range(0, 3));
        r.extent_z = 4'($urandom_range(0, 3));
      end
      send_request(r, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    rsp_ready <= steady_flow || ($urandom_range(0, 99) >= 23);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result with no request pending: in_bounds=%0b box_free=%0b cell_value=%0d",
                   $time, in_bounds, box_free, cell_value);
        end
      end else begin
        want = pending_results.pop_front();
        if (in_bounds !== want.in_bounds || box_free !== want.box_free ||
            cell_value !== want.cell_value) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: expected in_bounds=%0b box_free=%0b cell_value=%0d, got %0b %0b %0d",
                     $time, want.in_bounds, want.box_free, want.cell_value,
                     in_bounds, box_free, cell_value);
          end
        end
      end
    end
  end

  initial begin
    directed_rows.push_back(stim_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0));
    directed_rows.push_back(stim_row(OP_MARK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 255));
    directed_rows.push_back(stim_row(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 255));
    directed_rows.push_back(stim_row(OP_ADD, C_NEG1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(stim_row(OP_ADD, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(stim_row(OP_MARK, CELL64, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(stim_row(OP_ADD, CELL5, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 2));
    directed_rows.push_back(stim_row(OP_ADD, CELL5, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 4));
    directed_rows.push_back(stim_row(OP_DECAY, 0, 0, 0, 5, 0, 0, 0, 0, 0, 1, 1, 0, 3));
    directed_rows.push_back(stim_row(OP_DECAY, 0, 0, 0, 63, 63, 31, 0, 0, 0, 1, 1, 0, 0));
    directed_rows.push_back(stim_row(OP_DECAY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 255));
    directed_rows.push_back(stim_row(OP_MARK, CELL63, CELL63, CELL31, 0, 0, 0, 0, 0, 0,
                                     1, 1, 0, 255));
    directed_rows.push_back(stim_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 0, 255));
    directed_rows.push_back(stim_row(OP_QUERY, C_MIN, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0,
                                     1, 0, 1, 0));
    directed_rows.push_back(stim_row(OP_QUERY, CELL40, CELL40, CELL20, 0, 0, 0, 15, 8, 9,
                                     1, 1, 1, 0));
    directed_rows.push_back(stim_row(OP_QUERY, CELL63, CELL63, CELL31, 0, 0, 0, 15, 15, 15,
                                     1, 1, 0, 255));
    directed_rows.push_back(stim_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 4, 4, 1, 1, 1, 255));
    repeat (6) begin
      directed_rows.push_back(stim_row(OP_ADD, CELL10, CELL10, CELL10, 0, 0, 0, 0, 0, 0,
                                       0, 0, 0, 0));
    end
    directed_rows.push_back(stim_row(OP_DECAY, 0, 0, 0, 10, 10, 10, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(OP_QUERY, CELL10, CELL10, CELL10, 0, 0, 0, 1, 1, 1,
                                     0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[n]) begin
      send_request(directed_rows[n].req, directed_rows[n].known, directed_rows[n].res);
    end

    program_registers(0, 0, 0, INV_RES_RST, THRESH_RST, MARKER_RST);
    random_requests(200, 100);
    program_registers(C_MIN, C_MIN, C_MIN, 32'hFFFF_FFFF, 8'd0, 8'd0);
    random_requests(160, 0);
    program_registers(C_MAX, $urandom, $urandom, 32'd1, 8'd255, 8'd254);
    random_requests(160, 0);
    program_registers(int'($urandom_range(0, 524288)) - 262144,
                      int'($urandom_range(0, 524288)) - 262144,
                      int'($urandom_range(0, 524288)) - 262144,
                      $urandom_range(32768, 2097152), 8'($urandom_range(0, 255)),
                      8'($urandom_range(128, 255)));
    random_requests(260, 0);

    req_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_results.size() != 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
